// ----- sv/rmsrs_pkg.sv -----
`timescale 1ns / 1ps

package rmsrs_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_W         = 10;
  localparam int READING_W       = 10;
  localparam int RMS_W           = 18;
  localparam int SCALED_W        = 26;
  // Wide enough for 1000 * 1023 and for any sample count.
  localparam int DEN_W           = 20;
  localparam int FRAC_SHIFT      = 16;
  localparam int SCALE_SHIFT     = 18;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd200;
  localparam logic [COUNT_W-1:0] REF_MULT    = 10'd1000;

  // Word index of the sample count register.
  localparam logic REG_SAMPLE_COUNT = 1'b0;

  // Input operation codes.
  localparam logic OP_REFERENCE = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic set_start;  // completing sample: load first divide
    logic div_step;
    logic sqrt_step;
    logic div2_load;  // load the reference divide
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic set_last;   // next sample closes the set
    logic ref_zero;
    logic out_free;   // output register can take a new result
  } dp_status_t;

endpackage

// ----- sv/rmsrs_regs.sv -----
`timescale 1ns / 1ps

module rmsrs_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmsrs_pkg::ADDR_W-1:0]      paddr,
  input  logic [rmsrs_pkg::DATA_W-1:0]      pwdata,
  output logic [rmsrs_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  output logic [rmsrs_pkg::COUNT_W-1:0]     sample_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= rmsrs_pkg::COUNT_RESET;
    end else if (wr_en && (paddr[2] == rmsrs_pkg::REG_SAMPLE_COUNT)) begin
      sample_count <= pwdata[rmsrs_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      rmsrs_pkg::REG_SAMPLE_COUNT: prdata = rmsrs_pkg::DATA_W'(sample_count);
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- sv/rmsrs_ctrl.sv -----
`timescale 1ns / 1ps

module rmsrs_ctrl #(
  parameter int SAMPLE_BITS = rmsrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  operation,
  input  rmsrs_pkg::dp_status_t status,
  output rmsrs_pkg::ctrl_cmd_t  cmd,
  output logic                  in_stall
);

  localparam int DIV_W = 2 * SAMPLE_BITS + 8 + rmsrs_pkg::FRAC_SHIFT;
  localparam int RT_W  = DIV_W / 2;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last;

  assign last     = (cnt == '0);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept    = in_valid;
        cmd.set_start = in_valid && (operation == rmsrs_pkg::OP_SAMPLE) && status.set_last;
        if (cmd.set_start) begin
          state_next = ST_DIV1;
          cnt_next   = CNT_W'(DIV_W - 1);
        end
      end
      ST_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (last) begin
          state_next = ST_SQRT;
          cnt_next   = CNT_W'(RT_W - 1);
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (last) begin
          if (status.ref_zero) begin
            state_next = ST_OUT;
          end else begin
            cmd.div2_load = 1'b1;
            state_next    = ST_DIV2;
            cnt_next      = CNT_W'(DIV_W - 1);
          end
        end
      end
      ST_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- sv/rmsrs_dp.sv -----
`timescale 1ns / 1ps

module rmsrs_dp #(
  parameter int SAMPLE_BITS = rmsrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmsrs_pkg::ctrl_cmd_t                cmd,
  output rmsrs_pkg::dp_status_t               status,
  input  logic                                operation,
  input  logic [rmsrs_pkg::READING_W-1:0]     reading,
  input  logic [rmsrs_pkg::COUNT_W-1:0]       sample_count,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [rmsrs_pkg::RMS_W-1:0]         rms_value,
  output logic [rmsrs_pkg::SCALED_W-1:0]      scaled_value,
  output logic                                reference_zero
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SUM_W = 2 * SB + 8;
  localparam int DIV_W = SUM_W + rmsrs_pkg::FRAC_SHIFT;
  localparam int RT_W  = DIV_W / 2;
  localparam int DEN_W = rmsrs_pkg::DEN_W;
  localparam int CW    = rmsrs_pkg::COUNT_W;
  localparam logic [SB-1:0] MID = SB'(1) << (SB - 1);

  // Accumulation state
  logic [SUM_W-1:0]                     square_sum;
  logic [CW-1:0]                        samples_taken;
  logic [rmsrs_pkg::READING_W-1:0]      reference_reading;

  logic [SB-1:0]    rd, mag;
  logic [2*SB-1:0]  sq;
  logic [SUM_W-1:0] sum_new;
  logic [CW:0]      n, target;

  // Shared divider and root registers; the quotient register also feeds the root.
  logic [DIV_W-1:0] quo, quo_next;
  logic [DEN_W-1:0] den, rem, rem_next;
  logic [RT_W-1:0]  root, root_next;
  logic [RT_W:0]    sq_rem, sq_rem_next;

  logic [DEN_W:0]   d_sh;
  logic             d_ok;
  logic [RT_W+2:0]  s_sh, s_trial;
  logic             s_ok;
  logic [DEN_W-1:0] den_ref;

  assign rd      = SB'(reading);
  assign mag     = (rd >= MID) ? (rd - MID) : (MID - rd);
  assign sq      = mag * mag;
  assign sum_new = square_sum + SUM_W'(sq);
  assign n       = {1'b0, samples_taken} + 1'b1;
  assign target  = (sample_count == '0) ? (CW+1)'(1) : {1'b0, sample_count};
  assign den_ref = DEN_W'(reference_reading) * DEN_W'(rmsrs_pkg::REF_MULT);

  assign status.set_last = (n >= target);
  assign status.ref_zero = (reference_reading == '0);
  assign status.out_free = !out_valid || !out_stall;

  // Restoring divide, one quotient bit per cycle.
  assign d_sh = {rem, quo[DIV_W-1]};
  assign d_ok = (d_sh >= {1'b0, den});

  // Restoring square root, two radicand bits per cycle.
  assign s_sh    = {sq_rem, quo[DIV_W-1 -: 2]};
  assign s_trial = (RT_W+3)'({root, 2'b01});
  assign s_ok    = (s_sh >= s_trial);

  always_comb begin
    quo_next    = quo;
    rem_next    = rem;
    root_next   = root;
    sq_rem_next = sq_rem;
    if (cmd.div_step) begin
      quo_next = {quo[DIV_W-2:0], d_ok};
      rem_next = d_ok ? DEN_W'(d_sh - {1'b0, den}) : d_sh[DEN_W-1:0];
    end
    if (cmd.sqrt_step) begin
      quo_next    = {quo[DIV_W-3:0], 2'b00};
      root_next   = {root[RT_W-2:0], s_ok};
      sq_rem_next = s_ok ? (RT_W+1)'(s_sh - s_trial) : s_sh[RT_W:0];
    end
    if (cmd.set_start) begin
      quo_next    = {sum_new, {rmsrs_pkg::FRAC_SHIFT{1'b0}}};
      rem_next    = '0;
      root_next   = '0;
      sq_rem_next = '0;
    end
    if (cmd.div2_load) begin
      quo_next = DIV_W'({root_next, {rmsrs_pkg::SCALE_SHIFT{1'b0}}});
      rem_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    quo    <= quo_next;
    rem    <= rem_next;
    root   <= root_next;
    sq_rem <= sq_rem_next;
    if (cmd.set_start) begin
      den <= DEN_W'(n);
    end else if (cmd.div2_load) begin
      den <= den_ref;
    end
    if (cmd.out_load) begin
      rms_value      <= root[rmsrs_pkg::RMS_W-1:0];
      scaled_value   <= status.ref_zero ? '0 : quo[rmsrs_pkg::SCALED_W-1:0];
      reference_zero <= status.ref_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum        <= '0;
      samples_taken     <= '0;
      reference_reading <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (operation == rmsrs_pkg::OP_REFERENCE) begin
          // Only the low SAMPLE_BITS bits of a reading are meaningful.
          reference_reading <= rmsrs_pkg::READING_W'(rd);
        end else if (status.set_last) begin
          square_sum    <= '0;
          samples_taken <= '0;
        end else begin
          square_sum    <= sum_new;
          samples_taken <= n[CW-1:0];
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/rms_current_with_reference_scale_unit.sv -----
`timescale 1ns / 1ps

// RMS current meter with reference scaling.
// Input channel (in_valid / in_stall): operation 0 latches reading as the
// reference, operation 1 is a current sample. While in_stall is low,
// samples are taken one per cycle. The sample that completes a set of
// sample_count samples starts the result calculation, and in_stall stays
// high until the result is loaded into the output register. The calculation
// runs the shared restoring divider, 2*SAMPLE_BITS + 24 bits wide (one
// quotient bit per cycle, run twice, or only once when the reference is
// zero), and the square root (one root bit per cycle).
// Output channel (out_valid / out_stall): one beat per completed set. The
// output register holds a beat while out_stall is high; samples keep being
// taken meanwhile, and a later result waits in the block until it is free.
// sample_count sits at APB address 0; the user writes it only while idle,
// as the block itself does not enforce this. Reset (rst, synchronous) clears
// the sum, the count, the reference and the output valid, and sets sample_count to 200.
module rms_current_with_reference_scale_unit #(
  parameter int SAMPLE_BITS = rmsrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [rmsrs_pkg::READING_W-1:0]   reading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rmsrs_pkg::RMS_W-1:0]       rms_value,
  output logic [rmsrs_pkg::SCALED_W-1:0]    scaled_value,
  output logic                              reference_zero,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmsrs_pkg::ADDR_W-1:0]      paddr,
  input  logic [rmsrs_pkg::DATA_W-1:0]      pwdata,
  output logic [rmsrs_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  rmsrs_pkg::ctrl_cmd_t           cmd;
  rmsrs_pkg::dp_status_t          status;
  logic [rmsrs_pkg::COUNT_W-1:0]  sample_count;

  rmsrs_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_count (sample_count)
  );

  rmsrs_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  rmsrs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .reading        (reading),
    .sample_count   (sample_count),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .rms_value      (rms_value),
    .scaled_value   (scaled_value),
    .reference_zero (reference_zero)
  );

  // A result is never loaded over a beat that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output beat pending");

  // Once a set completes, no further input is taken until the result is out.
  a_busy_after_set: assert property (@(posedge clk) disable iff (rst)
    cmd.set_start |=> in_stall)
    else $error("input not stalled after completing sample");

  // The reference divide runs only with a nonzero reference.
  a_div2_ref: assert property (@(posedge clk) disable iff (rst)
    cmd.div2_load |-> !status.ref_zero)
    else $error("reference divide started with zero reference");

  // The output only becomes valid through a result load.
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without result load");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  // Divide, root and reference divide after the last sample of a set.
  localparam int CALC_CYCLES   = 111;
  localparam int SETTLE_CYCLES = CALC_CYCLES + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int MODE_BEATS    = 330;
  localparam int MIDPOINT      = 1 << (rmsrs_pkg::SAMPLE_BITS_DEF - 1);

  localparam logic OP_REFERENCE = rmsrs_pkg::OP_REFERENCE;
  localparam logic OP_SAMPLE    = rmsrs_pkg::OP_SAMPLE;
  localparam logic [rmsrs_pkg::ADDR_W-1:0] SAMPLE_COUNT_ADDR =
    {rmsrs_pkg::REG_SAMPLE_COUNT, 2'b00};

  typedef struct packed {
    logic [rmsrs_pkg::RMS_W-1:0]    rms;
    logic [rmsrs_pkg::SCALED_W-1:0] scaled;
    logic                           ref_zero;
  } rms_result_t;

  typedef struct packed {
    logic                            cfg_row;  // row writes the sample count instead of a beat
    logic [rmsrs_pkg::READING_W-1:0] value;
    logic                            op;
    logic                            typed;    // expected result written out in the row
    rms_result_t                     want;
  } dir_row_t;

  localparam rms_result_t NO_RESULT = '0;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            operation = OP_SAMPLE;
  logic [rmsrs_pkg::READING_W-1:0] reading = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [rmsrs_pkg::RMS_W-1:0]     rms_value;
  logic [rmsrs_pkg::SCALED_W-1:0]  scaled_value;
  logic                            reference_zero;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rmsrs_pkg::ADDR_W-1:0]    paddr = '0;
  logic [rmsrs_pkg::DATA_W-1:0]    pwdata = '0;
  logic [rmsrs_pkg::DATA_W-1:0]    prdata;
  logic                            pready;

  // Predictor state.
  longint unsigned                 sum_of_squares = 0;
  int unsigned                     set_fill = 0;
  logic [rmsrs_pkg::READING_W-1:0] latched_ref = '0;
  logic [rmsrs_pkg::COUNT_W-1:0]   set_size = rmsrs_pkg::COUNT_RESET;

  rms_result_t pending_results[$];
  rms_result_t head_result;

  int errors = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 51;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  rms_current_with_reference_scale_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .reading       (reading),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rms_value     (rms_value),
    .scaled_value  (scaled_value),
    .reference_zero(reference_zero),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  task automatic predict_rms(input logic op, input logic [rmsrs_pkg::READING_W-1:0] rd,
                             output bit done, output rms_result_t res);
    int              offset;
    int unsigned     n;
    int unsigned     target;
    longint unsigned rms;
    longint unsigned scaled;
    done = 1'b0;
    res = NO_RESULT;
    if (op == OP_REFERENCE) begin
      latched_ref = rd;
      return;
    end
    offset = int'(rd) - MIDPOINT;
    sum_of_squares += longint'(offset * offset);
    n = set_fill + 1;
    target = (set_size == 0) ? 1 : int'(set_size);
    if (n < target) begin
      set_fill = n;
      return;
    end
    rms = root_floor((sum_of_squares << rmsrs_pkg::FRAC_SHIFT) / n);
    if (latched_ref == 0) begin
      scaled = 0;
      res.ref_zero = 1'b1;
    end else begin
      scaled = (rms << rmsrs_pkg::SCALE_SHIFT) /
               (64'(rmsrs_pkg::REF_MULT) * 64'(latched_ref));
    end
    res.rms = rms[rmsrs_pkg::RMS_W-1:0];
    res.scaled = scaled[rmsrs_pkg::SCALED_W-1:0];
    sum_of_squares = 0;
    set_fill = 0;
    done = 1'b1;
  endtask

  task automatic send_beat(input logic op, input logic [rmsrs_pkg::READING_W-1:0] rd,
                           input logic typed, input rms_result_t want);
    bit          done;
    rms_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    reading <= rd;
    do @(posedge clk); while (in_stall);
    predict_rms(op, rd, done, res);
    if (done) begin
      pending_results.push_back(typed ? want : res);
    end
    beats_sent++;
  endtask

  // Stops offering beats until every expected result is out, then, if settle is set, idles for SETTLE_CYCLES.
  task automatic drain(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic apb_transfer(input logic wr, input logic [rmsrs_pkg::DATA_W-1:0] wdata,
                              output logic [rmsrs_pkg::DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= SAMPLE_COUNT_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic count_readback(input logic [rmsrs_pkg::COUNT_W-1:0] want);
    logic [rmsrs_pkg::DATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== rmsrs_pkg::DATA_W'(want)) begin
      $display("%0t: sample_count readback expected %0d actual %0d", $time, want, rdata);
      errors++;
    end
  endtask

  task automatic program_count(input logic [rmsrs_pkg::COUNT_W-1:0] value);
    logic [rmsrs_pkg::DATA_W-1:0] rdata;
    drain(1'b1);
    apb_transfer(1'b1, rmsrs_pkg::DATA_W'(value), rdata);
    set_size = value;
    settings_written++;
    count_readback(value);
  endtask

  function automatic logic [rmsrs_pkg::READING_W-1:0] pick_reading();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return rmsrs_pkg::READING_W'(MIDPOINT);
      default: return rmsrs_pkg::READING_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic send_random_beat();
    if ($urandom_range(99) < 2) begin
      drain(1'b0);
    end
    if ($urandom_range(99) < 12) begin
      send_beat(OP_REFERENCE, pick_reading(), 1'b0, NO_RESULT);
    end else begin
      send_beat(OP_SAMPLE, pick_reading(), 1'b0, NO_RESULT);
    end
  endtask

  // Output side: random stalls, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result rms %0d scaled %0d zero %0b", $time,
                 rms_value, scaled_value, reference_zero);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        if (rms_value !== head_result.rms) begin
          $display("%0t: rms_value expected %0d actual %0d", $time,
                   head_result.rms, rms_value);
          errors++;
        end
        if (scaled_value !== head_result.scaled) begin
          $display("%0t: scaled_value expected %0d actual %0d", $time,
                   head_result.scaled, scaled_value);
          errors++;
        end
        if (reference_zero !== head_result.ref_zero) begin
          $display("%0t: reference_zero expected %0b actual %0b", $time,
                   head_result.ref_zero, reference_zero);
          errors++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    dir_row_t dir_rows [25];
    int       mode_start;
    int       pick;
    int       count_value;

    dir_rows = '{
      '{1'b1, 10'd1,    OP_SAMPLE,    1'b0, NO_RESULT},
      // Reference still zero after reset, so the scaled value is forced to zero.
      '{1'b0, 10'd512,  OP_SAMPLE,    1'b1, '{18'd0, 26'd0, 1'b1}},
      '{1'b0, 10'd0,    OP_SAMPLE,    1'b1, '{18'd131072, 26'd0, 1'b1}},
      '{1'b0, 10'd1023, OP_SAMPLE,    1'b1, '{18'd130816, 26'd0, 1'b1}},
      '{1'b0, 10'd1023, OP_REFERENCE, 1'b0, NO_RESULT},
      '{1'b0, 10'd0,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd1023, OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd1,    OP_REFERENCE, 1'b0, NO_RESULT},
      '{1'b0, 10'd0,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd511,  OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd0,    OP_REFERENCE, 1'b0, NO_RESULT},
      '{1'b0, 10'd513,  OP_SAMPLE,    1'b1, '{18'd256, 26'd0, 1'b1}},
      '{1'b0, 10'd512,  OP_REFERENCE, 1'b0, NO_RESULT},
      '{1'b0, 10'd256,  OP_SAMPLE,    1'b0, NO_RESULT},
      // A count of zero behaves like a count of one.
      '{1'b1, 10'd0,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd768,  OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b1, 10'd5,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd0,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd1023, OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd600,  OP_SAMPLE,    1'b0, NO_RESULT},
      // Lowering the count mid-set closes the set on the next sample.
      '{1'b1, 10'd2,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd300,  OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd1023, OP_REFERENCE, 1'b0, NO_RESULT},
      '{1'b0, 10'd1,    OP_SAMPLE,    1'b0, NO_RESULT},
      '{1'b0, 10'd900,  OP_SAMPLE,    1'b0, NO_RESULT}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    count_readback(rmsrs_pkg::COUNT_RESET);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) begin
        program_count(dir_rows[i].value);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 14 : (m == 1) ? 51 : 0;
      recv_idle_pct = (m == 0) ? 51 : (m == 1) ? 14 : 0;
      mode_start = beats_sent;
      // One result per sample while the output is held, so the block backs up.
      program_count(1);
      hold_requests++;
      repeat (24) send_beat(OP_SAMPLE, pick_reading(), 1'b0, NO_RESULT);
      while (beats_sent - mode_start < MODE_BEATS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          count_value = 0;
        end else if (pick < 20) begin
          count_value = 1;
        end else if (pick < 23) begin
          count_value = 1023;
        end else if (pick < 75) begin
          count_value = $urandom_range(2, 8);
        end else begin
          count_value = $urandom_range(9, 60);
        end
        program_count(rmsrs_pkg::COUNT_W'(count_value));
        repeat ($urandom_range(8, 40)) send_random_beat();
      end
    end

    drain(1'b1);
    $display("Sent %0d input beats and checked %0d RMS results across %0d count settings,",
             beats_sent, results_checked, settings_written);
    $display("including zero references, counts lowered mid-set and long output holds.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
